>>> sv/trapz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile package
// Shared types, register indexes and constants of the trapezoid motion block.
// ----------------------------------------------------------------------------
package trapz_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE = 2'd2;

  localparam logic [32:0] POS_MAX = {33{1'b1}};
  localparam logic [31:0] SQRT_BIT_START = 32'h4000_0000;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    D_IDLE,
    D_START,
    D_DIV_TA,
    D_MUL1,
    D_MUL2,
    D_CMP,
    D_DIV_TM,
    D_FIN,
    D_DIV_Q,
    D_SQRT,
    D_TRI1,
    D_TRI2
  } derive_state_t;

  // Derived profile, to be held stable by the user while items flow; the block does not enforce it.
  typedef struct packed {
    logic        busy;
    logic        trap;   // trapezoid (1) or triangle (0)
    logic [15:0] accel;  // effective acceleration, never zero
    logic [15:0] vmax;   // effective velocity limit, never zero
    logic [15:0] ramp;   // ramp time
    logic [32:0] t1;     // end of cruise (ramp + cruise)
    logic [32:0] t2;     // end of move
    logic [31:0] att;    // accel * ramp * ramp
    logic [31:0] vpk;    // peak velocity
  } prof_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] e;      // time inside the ramp in use
    logic [32:0] x;      // time since the end of the up ramp (trapezoid)
  } item_t;

endpackage

>>> sv/trapz_derive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile derivation
// Holds the configuration registers and derives ramp and cruise limits with
// a shared restoring divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module trapz_derive import trapz_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output prof_t                  prof
);

  derive_state_t state, state_next;

  logic [15:0] accel, vmax;
  logic [31:0] distance;
  logic        trap;
  logic [15:0] ramp;
  logic [32:0] t1, t2;
  logic [31:0] att, vpk;

  // Scratch registers of the divider and square root.
  logic [31:0] dq;
  logic [15:0] rem;
  logic [15:0] dv;
  logic [4:0]  cnt;
  logic [31:0] sq_res, sq_bit;

  logic        cfg_hit;
  logic [16:0] r_sh;
  logic        r_ge;
  logic [15:0] r_new;
  logic [31:0] dq_new;
  logic [31:0] sq_sum;
  logic        sq_ge;
  logic [31:0] sq_res_new;
  logic [32:0] rest;
  logic        fits;
  logic [47:0] att_prod;

  assign cfg_hit = cfg_write && (cfg_index == REG_ACCEL || cfg_index == REG_VELOCITY ||
                                 cfg_index == REG_DISTANCE);

  assign r_sh   = {rem, dq[31]};
  assign r_ge   = r_sh >= {1'b0, dv};
  assign r_new  = r_ge ? 16'(r_sh - {1'b0, dv}) : r_sh[15:0];
  assign dq_new = {dq[30:0], r_ge};

  assign sq_sum     = sq_res + sq_bit;
  assign sq_ge      = dq >= sq_sum;
  assign sq_res_new = sq_ge ? (sq_res >> 1) + sq_bit : (sq_res >> 1);

  assign rest     = {1'b0, distance} - {1'b0, att};
  assign fits     = !rest[32] && (rest[31:0] >= {16'b0, vmax});
  assign att_prod = {16'b0, vpk} * {32'b0, ramp};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:   state_next = D_IDLE;
      D_START:  state_next = D_DIV_TA;
      D_DIV_TA: if (cnt == '1) state_next = D_MUL1;
      D_MUL1:   state_next = D_MUL2;
      D_MUL2:   state_next = D_CMP;
      D_CMP:    state_next = fits ? D_DIV_TM : D_DIV_Q;
      D_DIV_TM: if (cnt == '1) state_next = D_FIN;
      D_FIN:    state_next = D_IDLE;
      D_DIV_Q:  if (cnt == '1) state_next = D_SQRT;
      D_SQRT:   if (cnt[3:0] == '1) state_next = D_TRI1;
      D_TRI1:   state_next = D_TRI2;
      D_TRI2:   state_next = D_IDLE;
      default:  state_next = D_IDLE;
    endcase
    // Any register write restarts the derivation from the new values.
    if (cfg_hit) state_next = D_START;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel    <= 16'd1;
      vmax     <= 16'd1;
      distance <= '0;
      trap     <= 1'b1;
      ramp     <= '0;
      t1       <= '0;
      t2       <= '0;
      att      <= '0;
      vpk      <= 32'd1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ACCEL:    accel <= (cfg_data[15:0] == '0) ? 16'd1 : cfg_data[15:0];
          REG_VELOCITY: vmax  <= (cfg_data[15:0] == '0) ? 16'd1 : cfg_data[15:0];
          REG_DISTANCE: distance <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        D_DIV_TA: if (cnt == '1) ramp <= dq_new[15:0];
        D_MUL1:   vpk <= {16'b0, accel} * {16'b0, ramp};
        D_MUL2:   att <= {16'b0, vpk[15:0]} * {16'b0, ramp};
        D_DIV_TM: if (cnt == '1) t1 <= {1'b0, dq_new} + {17'b0, ramp};
        D_FIN: begin
          t2   <= t1 + {17'b0, ramp};
          vpk  <= {16'b0, vmax};
          trap <= 1'b1;
        end
        D_SQRT:   if (cnt[3:0] == '1) ramp <= sq_res_new[15:0];
        D_TRI1: begin
          vpk <= {16'b0, accel} * {16'b0, ramp};
          t1  <= {17'b0, ramp};
        end
        D_TRI2: begin
          att  <= att_prod[31:0];
          t2   <= {16'b0, ramp, 1'b0};
          trap <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_START: begin
        dq  <= {16'b0, vmax};
        dv  <= accel;
        rem <= '0;
        cnt <= '0;
      end
      D_DIV_TA, D_DIV_TM: begin
        dq  <= dq_new;
        rem <= r_new;
        cnt <= cnt + 5'd1;
      end
      D_CMP: begin
        dq  <= fits ? rest[31:0] : distance;
        dv  <= fits ? vmax : accel;
        rem <= '0;
        cnt <= '0;
      end
      D_DIV_Q: begin
        dq  <= dq_new;
        rem <= r_new;
        cnt <= cnt + 5'd1;
        if (cnt == '1) begin
          sq_res <= '0;
          sq_bit <= SQRT_BIT_START;
        end
      end
      D_SQRT: begin
        if (sq_ge) dq <= dq - sq_sum;
        sq_res <= sq_res_new;
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt + 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    prof.busy  = state != D_IDLE;
    prof.trap  = trap;
    prof.accel = accel;
    prof.vmax  = vmax;
    prof.ramp  = ramp;
    prof.t1    = t1;
    prof.t2    = t2;
    prof.att   = att;
    prof.vpk   = vpk;
  end

endmodule

>>> sv/trapz_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile front end
// Accepts time words, finds the phase and the phase-relative times, and
// hands the classified word to the queue.
// ----------------------------------------------------------------------------
module trapz_front import trapz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  prof_t       prof,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_tick,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  logic        held;
  logic        load;
  item_t       item;
  item_t       item_next;
  logic [32:0] t33, ramp33, from_ramp, from_t1;

  assign load      = !held || push_ready;
  assign in_ready  = !prof.busy && load;
  assign push_valid = held;
  assign push_item  = item;

  assign t33       = {1'b0, time_tick};
  assign ramp33    = {17'b0, prof.ramp};
  assign from_ramp = t33 - ramp33;
  assign from_t1   = t33 - prof.t1;

  always_comb begin
    item_next.phase = PH_DONE;
    item_next.e     = prof.ramp;
    item_next.x     = prof.trap ? prof.t1 : '0;
    if (prof.trap) begin
      if (t33 <= ramp33) begin
        item_next.phase = PH_ACCEL;
        item_next.e     = time_tick[15:0];
        item_next.x     = '0;
      end else if (t33 <= prof.t1) begin
        item_next.phase = PH_CRUISE;
        item_next.e     = '0;
        item_next.x     = from_ramp;
      end else if (t33 <= prof.t2) begin
        item_next.phase = PH_DECEL;
        item_next.e     = from_t1[15:0];
        item_next.x     = from_ramp;
      end
    end else begin
      // The triangle peaks exactly at the ramp time, which already counts as descent.
      if (t33 < ramp33) begin
        item_next.phase = PH_ACCEL;
        item_next.e     = time_tick[15:0];
      end else if (t33 <= prof.t2) begin
        item_next.phase = PH_DECEL;
        item_next.e     = from_t1[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

>>> sv/trapz_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module trapz_queue import trapz_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

>>> sv/trapz_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile back end
// Three-stage pipeline that forms position, velocity and acceleration from
// a classified word; the last stage is the output register.
// ----------------------------------------------------------------------------
module trapz_back import trapz_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  prof_t              prof,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  item_t              pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [32:0]        twice_position,
  output logic [31:0]        velocity,
  output logic signed [16:0] acceleration,
  output phase_t             profile_phase
);

  logic        adv;
  logic        s1_valid, s2_valid, s3_valid;
  phase_t      s1_phase, s2_phase;
  logic [15:0] s1_e;
  logic [31:0] s1_ae;
  logic [48:0] s1_w;
  logic [47:0] s2_aee;
  logic [50:0] s2_base;
  logic [31:0] s2_vel;

  logic [32:0] mx;
  logic [15:0] my;
  logic [31:0] vel_next;
  logic [50:0] pos_full;
  logic [32:0] pos_sat;
  logic [16:0] acc_next;

  // The whole pipeline holds while the output word waits.
  assign adv       = !s3_valid || out_ready;
  assign pop_ready = adv;
  assign out_valid = s3_valid;

  // Trapezoid multiplies the velocity limit by the long time; the triangle
  // multiplies its peak velocity by the short descent time.
  assign mx = prof.trap ? pop_item.x : {1'b0, prof.vpk};
  assign my = prof.trap ? prof.vmax : pop_item.e;

  always_comb begin
    case (s1_phase)
      PH_ACCEL:  vel_next = s1_ae;
      PH_CRUISE: vel_next = prof.vpk;
      PH_DECEL:  vel_next = prof.vpk - s1_ae;
      PH_DONE:   vel_next = '0;
      default:   vel_next = '0;
    endcase
  end

  assign pos_full = (s2_phase == PH_ACCEL) ? {3'b0, s2_aee} : s2_base - {3'b0, s2_aee};
  assign pos_sat  = (pos_full[50:33] != '0) ? POS_MAX : pos_full[32:0];

  always_comb begin
    case (s2_phase)
      PH_ACCEL: acc_next = {1'b0, prof.accel};
      PH_DECEL: acc_next = 17'd0 - {1'b0, prof.accel};
      default:  acc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_phase <= pop_item.phase;
      s1_e     <= pop_item.e;
      s1_ae    <= {16'b0, prof.accel} * {16'b0, pop_item.e};
      s1_w     <= {16'b0, mx} * {33'b0, my};

      s2_phase <= s1_phase;
      s2_aee   <= {16'b0, s1_ae} * {32'b0, s1_e};
      s2_base  <= (s1_phase == PH_ACCEL) ? '0 : {19'b0, prof.att} + {1'b0, s1_w, 1'b0};
      s2_vel   <= vel_next;

      twice_position <= pos_sat;
      velocity       <= s2_vel;
      acceleration   <= $signed(acc_next);
      profile_phase  <= s2_phase;
    end
  end

endmodule

>>> sv/trapezoid_motion_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid motion profile
// Evaluates a symmetric trapezoidal or triangular move at one time word per
// cycle: twice the position, velocity, acceleration and phase.
// ----------------------------------------------------------------------------
// Usage:
//   Write max_accel, max_velocity and move_distance through cfg_write,
//   cfg_index and cfg_data. Each write restarts the derivation of ramp and
//   cruise limits (a 32-step divider, then either a second division or a
//   division and a 16-step square root); in_ready is low while it runs.
//   Time words enter on in_valid/in_ready, results leave on
//   out_valid/out_ready in the same order.
//   From the accepting edge to out_valid a word passes a front register,
//   the queue, two multiply stages and the output register.
//   Throughput is one word per cycle; each multiplier is used once per word.
//   When the receiver stalls, the back pipeline holds and the queue fills;
//   the front keeps taking words until the queue and its own register are full.
//   Reset restores acceleration 1, velocity 1, distance 0 with zero ramp and
//   cruise times and empties all stages; no derivation runs after reset.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile import trapz_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            time_tick,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [32:0]            twice_position,
  output logic [31:0]            velocity,
  output logic signed [16:0]     acceleration,
  output logic [1:0]             profile_phase
);

  prof_t  prof;
  logic   push_valid, push_ready;
  item_t  push_item;
  logic   pop_valid, pop_ready;
  item_t  pop_item;
  phase_t phase_out;

  assign profile_phase = phase_out;

  trapz_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prof      (prof)
  );

  trapz_front u_front (
    .clk        (clk),
    .rst        (rst),
    .prof       (prof),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .time_tick  (time_tick),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  trapz_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  trapz_back u_back (
    .clk            (clk),
    .rst            (rst),
    .prof           (prof),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .twice_position (twice_position),
    .velocity       (velocity),
    .acceleration   (acceleration),
    .profile_phase  (phase_out)
  );

endmodule

>>> sv/trapz_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid profile port checker
// Watches the top-level ports for reset, stall, configuration and phase consistency.
// ----------------------------------------------------------------------------
module trapz_check import trapz_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_write,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [32:0]            twice_position,
  input logic [31:0]            velocity,
  input logic signed [16:0]     acceleration,
  input logic [1:0]             profile_phase
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(twice_position) &&
      $stable(velocity) && $stable(acceleration) && $stable(profile_phase))
    else $error("stalled output word changed or vanished");

  // A register write starts a derivation, so no time word may enter next cycle.
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index == REG_ACCEL || cfg_index == REG_VELOCITY ||
      cfg_index == REG_DISTANCE) |=> !in_ready)
    else $error("input accepted while profile limits are being derived");

  a_flat_accel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (profile_phase == PH_CRUISE || profile_phase == PH_DONE) |->
      acceleration == 17'sd0)
    else $error("nonzero acceleration in cruise or after the move");

  a_decel_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && profile_phase == PH_DECEL |-> acceleration[16])
    else $error("deceleration phase without negative acceleration");

endmodule

bind trapezoid_motion_profile trapz_check u_trapz_check (.*);

>>> tb/trapezoid_motion_profile_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid motion profile testbench
// Writes a series of acceleration, velocity and distance settings, offers time
// words with random gaps and receiver stalls, and checks every result word
// against a local profile calculator, field by field and in order.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_tb;
  import trapz_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RAND_PHASES     = 12;
  localparam int WORDS_PER_PHASE = 156;
  localparam int IDLE_LIMIT      = 5000;
  localparam int LONG_STALL      = 300;
  localparam int PRINT_LIMIT     = 40;
  localparam logic [63:0] POS_CEILING = 64'h1_FFFF_FFFF;

  typedef struct packed {
    logic [32:0] pos2;
    logic [31:0] vel;
    logic [16:0] acc;
    phase_t      phase;
  } profile_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            time_tick = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [32:0]            twice_position;
  logic [31:0]            velocity;
  logic signed [16:0]     acceleration;
  logic [1:0]             profile_phase;

  // Local copy of the registers and of the derived profile.
  logic [15:0] accel_reg = 16'd1;
  logic [15:0] vel_reg = 16'd1;
  logic [31:0] dist_reg = 32'd0;
  logic [31:0] ramp_ticks = 32'd0;
  logic [31:0] cruise_ticks = 32'd0;
  logic        triangle = 1'b0;

  logic [31:0]   pending_ticks[$];
  profile_word_t expected_profile[$];
  int words_pushed = 0;
  int words_accepted = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int rx_wait = 0;
  int stall_requests = 0;
  int stalls_served = 0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;

  trapezoid_motion_profile dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .time_tick(time_tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .twice_position(twice_position),
    .velocity(velocity),
    .acceleration(acceleration),
    .profile_phase(profile_phase)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] eff_accel();
    return (accel_reg == 16'd0) ? 64'd1 : {48'd0, accel_reg};
  endfunction

  function automatic logic [63:0] eff_vel();
    return (vel_reg == 16'd0) ? 64'd1 : {48'd0, vel_reg};
  endfunction

  function automatic logic [31:0] floor_sqrt(input logic [31:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = 64'd0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= {32'd0, x}) r = c;
    end
    return r[31:0];
  endfunction

  // Recompute ramp and cruise times from the current register values.
  function automatic void derive_profile();
    logic [63:0] a;
    logic [63:0] v;
    logic [63:0] ta;
    logic [63:0] q;
    logic signed [63:0] rest;
    a = eff_accel();
    v = eff_vel();
    ta = v / a;
    rest = $signed({32'd0, dist_reg}) - $signed(a * ta * ta);
    if (rest >= $signed(v)) begin
      triangle = 1'b0;
      ramp_ticks = ta[31:0];
      q = rest;
      q = q / v;
      cruise_ticks = q[31:0];
    end else begin
      triangle = 1'b1;
      q = {32'd0, dist_reg} / a;
      ramp_ticks = floor_sqrt(q[31:0]);
      cruise_ticks = 32'd0;
    end
  endfunction

  function automatic profile_word_t predict_profile(input logic [31:0] t_in);
    logic [63:0] a, v, t, ta, tm, d, pos, vel, neg;
    int sgn;
    profile_word_t r;
    a = eff_accel();
    v = eff_vel();
    t = {32'd0, t_in};
    ta = {32'd0, ramp_ticks};
    tm = {32'd0, cruise_ticks};
    neg = 64'd0 - a;
    if (!triangle) begin
      if (t <= ta) begin
        pos = a * t * t; vel = a * t; sgn = 1; r.phase = PH_ACCEL;
      end else if (t <= ta + tm) begin
        pos = a * ta * ta + 2 * v * (t - ta); vel = v; sgn = 0; r.phase = PH_CRUISE;
      end else begin
        d = (t <= 2 * ta + tm) ? t - ta - tm : ta;
        pos = a * ta * ta + 2 * v * tm + 2 * v * d - a * d * d;
        if (t <= 2 * ta + tm) begin
          vel = v - a * d; sgn = -1; r.phase = PH_DECEL;
        end else begin
          vel = 64'd0; sgn = 0; r.phase = PH_DONE;
        end
      end
    end else begin
      if (t < ta) begin
        pos = a * t * t; vel = a * t; sgn = 1; r.phase = PH_ACCEL;
      end else if (t <= 2 * ta) begin
        d = t - ta;
        pos = a * ta * ta + 2 * a * ta * d - a * d * d;
        vel = a * ta - a * d; sgn = -1; r.phase = PH_DECEL;
      end else begin
        pos = 2 * a * ta * ta; vel = 64'd0; sgn = 0; r.phase = PH_DONE;
      end
    end
    if (pos > POS_CEILING) pos = POS_CEILING;
    r.pos2 = pos[32:0];
    r.vel = vel[31:0];
    if (sgn > 0) r.acc = a[16:0];
    else if (sgn < 0) r.acc = neg[16:0];
    else r.acc = 17'd0;
    return r;
  endfunction

  // Time words spread over the whole move and beyond it, with extra weight on phase edges.
  function automatic logic [31:0] pick_time();
    logic [63:0] ta, tm, span, b;
    ta = {32'd0, ramp_ticks};
    tm = {32'd0, cruise_ticks};
    span = 2 * ta + tm + 2;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b = 64'($urandom_range(0, span[31:0]));
      5, 6: begin
        case ($urandom_range(0, 2))
          0: b = ta;
          1: b = ta + tm;
          default: b = 2 * ta + tm;
        endcase
        b = b + 64'($urandom_range(0, 2));
        if (b != 64'd0) b = b - 1;
      end
      7: begin
        b = 2 * ta + 2;
        if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
        b = 64'($urandom_range(0, b[31:0]));
      end
      8: b = 64'($urandom);
      default: b = $urandom_range(0, 1) ? 64'hFFFF_FFFF : 64'd0;
    endcase
    if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
    return b[31:0];
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 16));
      1: return 16'($urandom_range(1, 65535));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [31:0] pick_distance();
    logic [63:0] a, v, ta, base;
    a = eff_accel();
    v = eff_vel();
    ta = v / a;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1000);
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 1 << 20);
      default: begin
        // Hover around the border between triangle and trapezoid.
        base = a * ta * ta + 64'($urandom_range(0, 2 * v[31:0]));
        if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
        return base[31:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  task automatic offer_tick(input logic [31:0] t);
    pending_ticks.push_back(t);
    words_pushed++;
  endtask

  task automatic drain_block();
    while (words_accepted != words_pushed || expected_profile.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Called on a falling edge while the block is idle.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ACCEL: begin accel_reg = val[15:0]; derive_profile(); end
      REG_VELOCITY: begin vel_reg = val[15:0]; derive_profile(); end
      REG_DISTANCE: begin dist_reg = val; derive_profile(); end
      default: ;
    endcase
    repeat (2) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_valid && !in_fire) begin
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 7) != 0)) begin
      in_valid <= 1'b1;
      time_tick <= pending_ticks.pop_front();
    end else begin
      in_valid <= 1'b0;
      if (!calm && pending_ticks.size() != 0) in_gap = $urandom_range(0, 5);
    end
  end

  // Receiver: short random stalls, plus an occasional long one.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (stalls_served != stall_requests) begin
      stalls_served++;
      rx_wait = LONG_STALL;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_wait = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    profile_word_t oldest;
    if (rst) begin
      in_fire <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_fire <= in_valid && in_ready;
      // Results are handled before new words so a same-edge word is never matched.
      if (out_valid && out_ready) begin
        if (expected_profile.size() == 0) begin
          report_mismatch("result with no pending word", {31'd0, twice_position}, 64'd0);
        end else begin
          oldest = expected_profile.pop_front();
          if (twice_position !== oldest.pos2)
            report_mismatch("twice_position", {31'd0, twice_position}, {31'd0, oldest.pos2});
          if (velocity !== oldest.vel)
            report_mismatch("velocity", {32'd0, velocity}, {32'd0, oldest.vel});
          if ($unsigned(acceleration) !== oldest.acc)
            report_mismatch("acceleration", {47'd0, $unsigned(acceleration)},
                            {47'd0, oldest.acc});
          if (profile_phase !== oldest.phase)
            report_mismatch("profile_phase", {62'd0, profile_phase}, {62'd0, oldest.phase});
        end
      end
      if (in_valid && in_ready) begin
        expected_profile.push_back(predict_profile(time_tick));
        words_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("trapezoid_motion_profile test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] rate;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Profile straight out of reset, then a write to the unused index.
    offer_tick(32'd0);
    offer_tick(32'd1);
    offer_tick(32'hFFFF_FFFF);
    drain_block();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    offer_tick(32'd0);
    offer_tick(32'd1);
    drain_block();

    // Zero rates count as one.
    write_register(REG_ACCEL, 32'd0);
    write_register(REG_VELOCITY, 32'd0);
    write_register(REG_DISTANCE, 32'd10);
    offer_tick(32'd0);
    offer_tick(32'd1);
    offer_tick(32'd2);
    offer_tick(32'd10);
    offer_tick(32'd11);
    offer_tick(32'hFFFF_FFFF);
    drain_block();

    write_register(REG_ACCEL, 32'd65535);
    write_register(REG_VELOCITY, 32'd65535);
    write_register(REG_DISTANCE, 32'hFFFF_FFFF);
    offer_tick(32'd0);
    offer_tick(32'd1);
    offer_tick(32'd65537);
    offer_tick(32'd65538);
    offer_tick(32'hFFFF_FFFF);
    drain_block();

    // Longest ramp the registers allow.
    write_register(REG_ACCEL, 32'd1);
    offer_tick(32'd1000);
    offer_tick(32'd65535);
    offer_tick(32'd65537);
    offer_tick(32'd131072);
    offer_tick(32'd131073);
    drain_block();

    // Short move that never reaches the velocity limit.
    write_register(REG_ACCEL, 32'd3);
    write_register(REG_DISTANCE, 32'd1000);
    offer_tick(32'd17);
    offer_tick(32'd18);
    offer_tick(32'd36);
    offer_tick(32'd37);
    drain_block();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        rate = pick_rate();
        write_register(REG_ACCEL, {16'd0, rate});
      end
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        rate = pick_rate();
        write_register(REG_VELOCITY, {16'd0, rate});
      end
      if (ph == 0 || $urandom_range(0, 3) != 0)
        write_register(REG_DISTANCE, pick_distance());
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        offer_tick(pick_time());
      // Hold the receiver off so the queue fills and the input stalls.
      if (ph == 1 || ph == 6) stall_requests++;
      drain_block();
    end

    if (mismatches == 0) begin
      $display("trapezoid_motion_profile test passed");
    end else begin
      $display("trapezoid_motion_profile test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/trapz_pkg.sv
sv/trapz_derive.sv
sv/trapz_front.sv
sv/trapz_queue.sv
sv/trapz_back.sv
sv/trapezoid_motion_profile.sv
sv/trapz_check.sv
tb/trapezoid_motion_profile_tb.sv
